@@ src/wav_pcm_stream_parser_assert.svh @@
// assertion macros for the wav pcm stream parser
// expects clk_i and rst_ni in the scope of each use
`ifndef WAV_PCM_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM_STREAM_PARSER_ASSERT_SVH

// property that must hold at every edge out of reset
`define WPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at the same edge
`define WPP_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

@@ src/wpp_pkg.sv @@
// shared types, codes and header constants of the wav pcm stream parser
// no dependencies
package wpp_pkg;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_RIFF     = 3'd0;
  localparam logic [2:0] ERR_WAVE     = 3'd1;
  localparam logic [2:0] ERR_FMT_ID   = 3'd2;
  localparam logic [2:0] ERR_FMT_SIZE = 3'd3;
  localparam logic [2:0] ERR_DATA_ID  = 3'd4;
  localparam logic [2:0] ERR_SMP_SIZE = 3'd5;

  localparam logic [5:0] HDR_LAST = 6'd43;

  // byte lanes, lane 0 first in the stream
  localparam logic [3:0][7:0] ID_RIFF  = {8'h46, 8'h46, 8'h49, 8'h52};
  localparam logic [3:0][7:0] ID_WAVE  = {8'h45, 8'h56, 8'h41, 8'h57};
  localparam logic [3:0][7:0] ID_FMT   = {8'h20, 8'h74, 8'h6D, 8'h66};
  localparam logic [3:0][7:0] SZ_FMT   = {8'h00, 8'h00, 8'h00, 8'h10};
  localparam logic [3:0][7:0] ID_DATA  = {8'h61, 8'h74, 8'h61, 8'h64};

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_STOP   = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_HEADER = 2'd1,
    OP_ERROR  = 2'd2
  } op_e;

  typedef struct packed {
    logic [15:0] fmt_code;
    logic [15:0] chan_count;
    logic [31:0] smp_rate;
    logic [31:0] bytes_per_sec;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
  } hdr_t;

  // one queue entry from the classifier to the packer
  typedef struct packed {
    op_e        op;
    logic [2:0] code;
    logic [7:0] data;
    logic [1:0] lane;
    logic       emit;
    logic       last;
    logic [1:0] bcode;
    hdr_t       hdr;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample;
    logic        last;
    logic [2:0]  code;
    hdr_t        hdr;
  } res_t;

  typedef struct packed {
    logic       check;
    logic [2:0] code;
    logic [7:0] exp_byte;
  } hchk_t;

  function automatic hchk_t hdr_check(input logic [5:0] pos);
    hchk_t r;
    r.check    = 1'b1;
    r.code     = ERR_RIFF;
    r.exp_byte = ID_RIFF[pos[1:0]];
    priority if (pos <= 6'd3) begin
      r.code     = ERR_RIFF;
      r.exp_byte = ID_RIFF[pos[1:0]];
    end else if (pos >= 6'd8 && pos <= 6'd11) begin
      r.code     = ERR_WAVE;
      r.exp_byte = ID_WAVE[pos[1:0]];
    end else if (pos >= 6'd12 && pos <= 6'd15) begin
      r.code     = ERR_FMT_ID;
      r.exp_byte = ID_FMT[pos[1:0]];
    end else if (pos >= 6'd16 && pos <= 6'd19) begin
      r.code     = ERR_FMT_SIZE;
      r.exp_byte = SZ_FMT[pos[1:0]];
    end else if (pos >= 6'd36 && pos <= 6'd39) begin
      r.code     = ERR_DATA_ID;
      r.exp_byte = ID_DATA[pos[1:0]];
    end else begin
      r.check = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ src/wpp_front.sv @@
// byte classifier: header check and capture, data byte counting
// depends on wpp_pkg
module wpp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_in_i,
  input  logic              first_i,
  output logic              push_o,
  output wpp_pkg::entry_t   entry_o
);

  wpp_pkg::phase_e phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [1:0]  idx_q, idx_d;
  logic [1:0]  bcode_q, bcode_d;
  logic [31:0] rem_q, rem_d;
  wpp_pkg::hdr_t fmt_q, fmt_d;

  wpp_pkg::phase_e ph;
  logic [5:0]      pos;
  wpp_pkg::hchk_t  chk;
  logic            mismatch;
  logic            bits_ok;
  logic            end_data;
  logic            emit;
  logic [2:0]      bits_m1;

  assign ph       = first_i ? wpp_pkg::PH_HEADER : phase_q;
  assign pos      = first_i ? 6'd0 : pos_q;
  assign chk      = wpp_pkg::hdr_check(pos);
  assign mismatch = chk.check && (byte_in_i != chk.exp_byte);
  assign bits_ok  = (fmt_q.sample_bits == 16'd8)  || (fmt_q.sample_bits == 16'd16) ||
                    (fmt_q.sample_bits == 16'd24) || (fmt_q.sample_bits == 16'd32);
  assign bits_m1  = fmt_q.sample_bits[5:3] - 3'd1;
  assign end_data = (rem_q == 32'd1);
  assign emit     = (idx_q == bcode_q) || end_data;

  always_comb begin
    phase_d = ph;
    pos_d   = pos;
    idx_d   = idx_q;
    bcode_d = bcode_q;
    rem_d   = rem_q;
    fmt_d   = fmt_q;
    push_o  = 1'b0;
    entry_o = '0;
    entry_o.op    = wpp_pkg::OP_DATA;
    entry_o.data  = byte_in_i;
    entry_o.lane  = idx_q;
    entry_o.emit  = emit;
    entry_o.last  = end_data;
    entry_o.bcode = bcode_q;

    // field capture
    if (pos == 6'd20 || pos == 6'd21) fmt_d.fmt_code[pos[0]*8 +: 8] = byte_in_i;
    if (pos == 6'd22 || pos == 6'd23) fmt_d.chan_count[pos[0]*8 +: 8] = byte_in_i;
    if (pos >= 6'd24 && pos <= 6'd27) fmt_d.smp_rate[pos[1:0]*8 +: 8] = byte_in_i;
    if (pos >= 6'd28 && pos <= 6'd31) fmt_d.bytes_per_sec[pos[1:0]*8 +: 8] = byte_in_i;
    if (pos == 6'd32 || pos == 6'd33) fmt_d.frame_bytes[pos[0]*8 +: 8] = byte_in_i;
    if (pos == 6'd34 || pos == 6'd35) fmt_d.sample_bits[pos[0]*8 +: 8] = byte_in_i;
    if (pos >= 6'd40 && pos <= 6'd43) fmt_d.data_size[pos[1:0]*8 +: 8] = byte_in_i;

    unique case (ph)
      wpp_pkg::PH_HEADER: begin
        if (mismatch) begin
          push_o       = 1'b1;
          entry_o.op   = wpp_pkg::OP_ERROR;
          entry_o.code = chk.code;
          phase_d      = wpp_pkg::PH_STOP;
        end else if (pos == wpp_pkg::HDR_LAST) begin
          push_o = 1'b1;
          if (!bits_ok) begin
            entry_o.op   = wpp_pkg::OP_ERROR;
            entry_o.code = wpp_pkg::ERR_SMP_SIZE;
            phase_d      = wpp_pkg::PH_STOP;
          end else begin
            entry_o.op  = wpp_pkg::OP_HEADER;
            entry_o.hdr = fmt_d;
            rem_d       = fmt_d.data_size;
            idx_d       = 2'd0;
            bcode_d     = bits_m1[1:0];
            phase_d     = (fmt_d.data_size == 32'd0) ? wpp_pkg::PH_STOP : wpp_pkg::PH_DATA;
          end
        end else begin
          pos_d = pos + 6'd1;
        end
      end
      wpp_pkg::PH_DATA: begin
        push_o = 1'b1;
        rem_d  = rem_q - 32'd1;
        idx_d  = emit ? 2'd0 : idx_q + 2'd1;
        if (end_data) phase_d = wpp_pkg::PH_STOP;
      end
      wpp_pkg::PH_STOP: begin
      end
      default: begin
        phase_d = wpp_pkg::PH_STOP;
      end
    endcase
    if (!accept_i) push_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wpp_pkg::PH_HEADER;
      pos_q   <= 6'd0;
      idx_q   <= 2'd0;
      bcode_q <= 2'd0;
      rem_q   <= 32'd0;
      fmt_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      bcode_q <= bcode_d;
      rem_q   <= rem_d;
      fmt_q   <= fmt_d;
    end
  end

endmodule

@@ src/wpp_fifo.sv @@
// short queue of classified transactions between classifier and packer
// depends on wpp_pkg
module wpp_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wpp_pkg::entry_t data_i,
  input  logic            pop_i,
  output wpp_pkg::entry_t data_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  wpp_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/wpp_back.sv @@
// sample packer and result register
// depends on wpp_pkg
module wpp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  wpp_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wpp_pkg::res_t   res_o
);

  logic          valid_q;
  logic [31:0]   acc_q, acc_d;
  logic [31:0]   acc_new;
  logic [31:0]   ext;
  logic          sign;
  wpp_pkg::res_t res_q, res_d;
  logic          load;

  assign pop_o       = avail_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    acc_new = acc_q;
    acc_new[entry_i.lane*8 +: 8] = entry_i.data;
    sign = acc_new[{entry_i.bcode, 3'b111}];
    unique case (entry_i.bcode)
      2'd0:    ext = 32'hFFFF_FF00;
      2'd1:    ext = 32'hFFFF_0000;
      2'd2:    ext = 32'hFF00_0000;
      default: ext = 32'h0000_0000;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    load  = 1'b0;
    res_d = '0;
    if (pop_o) begin
      unique case (entry_i.op)
        wpp_pkg::OP_DATA: begin
          if (entry_i.emit) begin
            load         = 1'b1;
            acc_d        = 32'd0;
            res_d.kind   = wpp_pkg::KIND_SAMPLE;
            res_d.sample = sign ? (acc_new | ext) : acc_new;
            res_d.last   = entry_i.last;
          end else begin
            acc_d = acc_new;
          end
        end
        wpp_pkg::OP_HEADER: begin
          load       = 1'b1;
          acc_d      = 32'd0;
          res_d.kind = wpp_pkg::KIND_HEADER;
          res_d.hdr  = entry_i.hdr;
        end
        wpp_pkg::OP_ERROR: begin
          load       = 1'b1;
          res_d.kind = wpp_pkg::KIND_ERROR;
          res_d.code = entry_i.code;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acc_q   <= 32'd0;
    end else begin
      acc_q <= acc_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end

endmodule

@@ src/wav_pcm_stream_parser.sv @@
// wav pcm stream parser, top level: classifier, queue, packer
// one byte per cycle while in_ready_o is high; a result passes through the queue and then the output register
// classified entries pass through a QUEUE_DEPTH entry queue, the output register frees on out_ready_i
// reset: parser waits for header byte 0, queue and output register empty
// depends on wpp_pkg, wpp_front, wpp_fifo, wpp_back and the assertion header
`include "wav_pcm_stream_parser_assert.svh"

module wav_pcm_stream_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_in_i,
  input  logic               first_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] sample_o,
  output logic               last_o,
  output logic [2:0]         error_code_o,
  output logic [15:0]        fmt_code_o,
  output logic [15:0]        chan_count_o,
  output logic [31:0]        smp_rate_o,
  output logic [31:0]        bytes_per_sec_o,
  output logic [15:0]        frame_bytes_o,
  output logic [15:0]        sample_bits_o,
  output logic [31:0]        data_size_o
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;
  wpp_pkg::entry_t push_entry;
  wpp_pkg::entry_t head_entry;
  wpp_pkg::res_t   res;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  wpp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_in_i (byte_in_i),
    .first_i   (first_i),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  wpp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (head_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  wpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (!empty),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o          = res.kind;
  assign sample_o        = $signed(res.sample);
  assign last_o          = res.last;
  assign error_code_o    = res.code;
  assign fmt_code_o      = res.hdr.fmt_code;
  assign chan_count_o    = res.hdr.chan_count;
  assign smp_rate_o      = res.hdr.smp_rate;
  assign bytes_per_sec_o = res.hdr.bytes_per_sec;
  assign frame_bytes_o   = res.hdr.frame_bytes;
  assign sample_bits_o   = res.hdr.sample_bits;
  assign data_size_o     = res.hdr.data_size;

  `WPP_ASSERT_IMPL(a_kind_legal, out_valid_o,
    kind_o == wpp_pkg::KIND_SAMPLE || kind_o == wpp_pkg::KIND_HEADER ||
    kind_o == wpp_pkg::KIND_ERROR, "illegal result kind")
  `WPP_ASSERT_IMPL(a_last_only_sample, out_valid_o && kind_o != wpp_pkg::KIND_SAMPLE,
    !last_o && sample_o == 32'sd0, "sample fields set on non-sample transaction")
  `WPP_ASSERT_IMPL(a_hdr_only_header, out_valid_o && kind_o != wpp_pkg::KIND_HEADER,
    data_size_o == 32'd0 && sample_bits_o == 16'd0 && smp_rate_o == 32'd0,
    "header fields set on non-header transaction")
  `WPP_ASSERT_IMPL(a_code_only_error, out_valid_o && kind_o != wpp_pkg::KIND_ERROR,
    error_code_o == wpp_pkg::ERR_RIFF, "error code set on non-error transaction")
  `WPP_ASSERT(a_no_pop_empty, !(pop && empty), "queue popped while empty")

endmodule

@@ tb/wav_parse_checker.sv @@
`timescale 1ns / 1ps
// checker for the wav pcm stream parser: watches both channels, predicts each result
// from the accepted bytes and compares it field by field. depends on wpp_pkg
module wav_parse_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         byte_i,
  input  logic               first_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] sample_i,
  input  logic               last_i,
  input  logic [2:0]         error_code_i,
  input  logic [15:0]        fmt_code_i,
  input  logic [15:0]        chan_count_i,
  input  logic [31:0]        smp_rate_i,
  input  logic [31:0]        bytes_per_sec_i,
  input  logic [15:0]        frame_bytes_i,
  input  logic [15:0]        sample_bits_i,
  input  logic [31:0]        data_size_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  wpp_pkg::phase_e parse_phase;
  logic [5:0]      hdr_pos;
  wpp_pkg::hdr_t   fmt_seen;
  logic [31:0]     bytes_left;
  logic [1:0]      byte_lane;
  logic [31:0]     sample_acc;

  wpp_pkg::res_t   expected_results[$];
  int              mismatches;
  bit              produced;
  wpp_pkg::res_t   predicted;
  wpp_pkg::res_t   observed;
  wpp_pkg::res_t   oldest;

  function automatic void clear_parser();
    parse_phase = wpp_pkg::PH_HEADER;
    hdr_pos     = '0;
    fmt_seen    = '0;
    bytes_left  = '0;
    byte_lane   = '0;
    sample_acc  = '0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic restart, output bit has_res,
                            output wpp_pkg::res_t r);
    logic        checked;
    logic [2:0]  code;
    logic [7:0]  want;
    logic [2:0]  nbytes;
    logic [2:0]  idx;
    logic [31:0] v;
    logic        at_end;
    r       = '0;
    has_res = 1'b0;
    if (restart) clear_parser();
    case (parse_phase)
      wpp_pkg::PH_HEADER: begin
        checked = 1'b1;
        code    = wpp_pkg::ERR_RIFF;
        want    = '0;
        case (hdr_pos[5:2])
          4'd0: begin code = wpp_pkg::ERR_RIFF;     want = wpp_pkg::ID_RIFF[hdr_pos[1:0]]; end
          4'd2: begin code = wpp_pkg::ERR_WAVE;     want = wpp_pkg::ID_WAVE[hdr_pos[1:0]]; end
          4'd3: begin code = wpp_pkg::ERR_FMT_ID;   want = wpp_pkg::ID_FMT[hdr_pos[1:0]];  end
          4'd4: begin code = wpp_pkg::ERR_FMT_SIZE; want = wpp_pkg::SZ_FMT[hdr_pos[1:0]];  end
          4'd9: begin code = wpp_pkg::ERR_DATA_ID;  want = wpp_pkg::ID_DATA[hdr_pos[1:0]]; end
          default: checked = 1'b0;
        endcase
        if (checked && b != want) begin
          parse_phase = wpp_pkg::PH_STOP;
          r.kind      = wpp_pkg::KIND_ERROR;
          r.code      = code;
          has_res     = 1'b1;
        end else begin
          // little-endian capture of the format fields and the data size
          case (hdr_pos[5:2])
            4'd5: begin
              if (!hdr_pos[1]) fmt_seen.fmt_code[hdr_pos[0]*8 +: 8] = b;
              else             fmt_seen.chan_count[hdr_pos[0]*8 +: 8] = b;
            end
            4'd6: fmt_seen.smp_rate[hdr_pos[1:0]*8 +: 8] = b;
            4'd7: fmt_seen.bytes_per_sec[hdr_pos[1:0]*8 +: 8] = b;
            4'd8: begin
              if (!hdr_pos[1]) fmt_seen.frame_bytes[hdr_pos[0]*8 +: 8] = b;
              else             fmt_seen.sample_bits[hdr_pos[0]*8 +: 8] = b;
            end
            4'd10: bytes_left[hdr_pos[1:0]*8 +: 8] = b;
            default: ;
          endcase
          if (hdr_pos != wpp_pkg::HDR_LAST) begin
            hdr_pos = hdr_pos + 6'd1;
          end else if (fmt_seen.sample_bits != 16'd8 && fmt_seen.sample_bits != 16'd16 &&
                       fmt_seen.sample_bits != 16'd24 &&
                       fmt_seen.sample_bits != 16'd32) begin
            parse_phase = wpp_pkg::PH_STOP;
            r.kind      = wpp_pkg::KIND_ERROR;
            r.code      = wpp_pkg::ERR_SMP_SIZE;
            has_res     = 1'b1;
          end else begin
            parse_phase      = (bytes_left == 0) ? wpp_pkg::PH_STOP : wpp_pkg::PH_DATA;
            byte_lane        = '0;
            sample_acc       = '0;
            r.kind           = wpp_pkg::KIND_HEADER;
            r.hdr            = fmt_seen;
            r.hdr.data_size  = bytes_left;
            has_res          = 1'b1;
          end
        end
      end
      wpp_pkg::PH_DATA: begin
        nbytes = fmt_seen.sample_bits[5:3];
        sample_acc[byte_lane*8 +: 8] = b;
        idx        = {1'b0, byte_lane} + 3'd1;
        bytes_left = bytes_left - 32'd1;
        at_end     = (bytes_left == 0);
        if (idx < nbytes && !at_end) begin
          byte_lane = idx[1:0];
        end else begin
          v = sample_acc;
          // sign from the top bit of the nominal width, also on a short sample
          if (fmt_seen.sample_bits < 16'd32 && v[fmt_seen.sample_bits - 16'd1])
            v = v | (32'hFFFF_FFFF << fmt_seen.sample_bits);
          sample_acc = '0;
          byte_lane  = '0;
          if (at_end) parse_phase = wpp_pkg::PH_STOP;
          r.kind   = wpp_pkg::KIND_SAMPLE;
          r.sample = v;
          r.last   = at_end;
          has_res  = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_results.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        parse_byte(byte_i, first_i, produced, predicted);
        if (produced) expected_results.insert(expected_results.size(), predicted);
      end
      if (out_valid_i && out_ready_i) begin
        observed.kind              = kind_i;
        observed.sample            = sample_i;
        observed.last              = last_i;
        observed.code              = error_code_i;
        observed.hdr.fmt_code      = fmt_code_i;
        observed.hdr.chan_count    = chan_count_i;
        observed.hdr.smp_rate      = smp_rate_i;
        observed.hdr.bytes_per_sec = bytes_per_sec_i;
        observed.hdr.frame_bytes   = frame_bytes_i;
        observed.hdr.sample_bits   = sample_bits_i;
        observed.hdr.data_size     = data_size_i;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result transaction with none expected, kind %0h sample %0h",
                   $time, kind_i, sample_i);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          mismatches += field_diff("kind", 32'(oldest.kind), 32'(observed.kind));
          mismatches += field_diff("sample", oldest.sample, observed.sample);
          mismatches += field_diff("last", 32'(oldest.last), 32'(observed.last));
          mismatches += field_diff("error_code", 32'(oldest.code), 32'(observed.code));
          mismatches += field_diff("fmt_code", 32'(oldest.hdr.fmt_code),
                                   32'(observed.hdr.fmt_code));
          mismatches += field_diff("chan_count", 32'(oldest.hdr.chan_count),
                                   32'(observed.hdr.chan_count));
          mismatches += field_diff("smp_rate", oldest.hdr.smp_rate, observed.hdr.smp_rate);
          mismatches += field_diff("bytes_per_sec", oldest.hdr.bytes_per_sec,
                                   observed.hdr.bytes_per_sec);
          mismatches += field_diff("frame_bytes", 32'(oldest.hdr.frame_bytes),
                                   32'(observed.hdr.frame_bytes));
          mismatches += field_diff("sample_bits", 32'(oldest.hdr.sample_bits),
                                   32'(observed.hdr.sample_bits));
          mismatches += field_diff("data_size", oldest.hdr.data_size, observed.hdr.data_size);
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// top of the wav pcm stream parser testbench: clock, reset, byte stream and result stalls
// depends on wpp_pkg, wav_pcm_stream_parser and wav_parse_checker
module tb_top;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         byte_in_i;
  logic               first_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         kind_o;
  logic signed [31:0] sample_o;
  logic               last_o;
  logic [2:0]         error_code_o;
  logic [15:0]        fmt_code_o;
  logic [15:0]        chan_count_o;
  logic [31:0]        smp_rate_o;
  logic [31:0]        bytes_per_sec_o;
  logic [15:0]        frame_bytes_o;
  logic [15:0]        sample_bits_o;
  logic [31:0]        data_size_o;

  int                 chk_fails;
  int                 chk_pending;

  logic [7:0]         file_q[$];
  int                 work_items;
  int                 file_cnt;
  bit                 no_idle;
  bit                 hold_req;

  wav_pcm_stream_parser i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_in_i        (byte_in_i),
    .first_i          (first_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .sample_o         (sample_o),
    .last_o           (last_o),
    .error_code_o     (error_code_o),
    .fmt_code_o       (fmt_code_o),
    .chan_count_o     (chan_count_o),
    .smp_rate_o       (smp_rate_o),
    .bytes_per_sec_o  (bytes_per_sec_o),
    .frame_bytes_o    (frame_bytes_o),
    .sample_bits_o    (sample_bits_o),
    .data_size_o      (data_size_o)
  );

  wav_parse_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .byte_i           (byte_in_i),
    .first_i          (first_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_i           (kind_o),
    .sample_i         (sample_o),
    .last_i           (last_o),
    .error_code_i     (error_code_o),
    .fmt_code_i       (fmt_code_o),
    .chan_count_i     (chan_count_o),
    .smp_rate_i       (smp_rate_o),
    .bytes_per_sec_i  (bytes_per_sec_o),
    .frame_bytes_i    (frame_bytes_o),
    .sample_bits_i    (sample_bits_o),
    .data_size_i      (data_size_o),
    .fail_count_o     (chk_fails),
    .pending_o        (chk_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off counted here
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 150;
      end
      out_ready_i <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 8);
      if (hold_left > 0) hold_left--;
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'h80;
      2:       return 8'h7F;
      3:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic wpp_pkg::hdr_t rand_hdr(logic [15:0] bits, logic [31:0] size);
    wpp_pkg::hdr_t h;
    h.fmt_code      = 16'(pick32());
    h.chan_count    = 16'(pick32());
    h.smp_rate      = pick32();
    h.bytes_per_sec = pick32();
    h.frame_bytes   = 16'(pick32());
    h.sample_bits   = bits;
    h.data_size     = size;
    return h;
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_q.insert(file_q.size(), v[i*8 +: 8]);
  endfunction

  function automatic void put_id(logic [3:0][7:0] id);
    for (int i = 0; i < 4; i++) file_q.insert(file_q.size(), id[i]);
  endfunction

  function automatic void build_header(wpp_pkg::hdr_t h);
    file_q.delete();
    put_id(wpp_pkg::ID_RIFF);
    put_le($urandom, 4);
    put_id(wpp_pkg::ID_WAVE);
    put_id(wpp_pkg::ID_FMT);
    put_id(wpp_pkg::SZ_FMT);
    put_le(32'(h.fmt_code), 2);
    put_le(32'(h.chan_count), 2);
    put_le(h.smp_rate, 4);
    put_le(h.bytes_per_sec, 4);
    put_le(32'(h.frame_bytes), 2);
    put_le(32'(h.sample_bits), 2);
    put_id(wpp_pkg::ID_DATA);
    put_le(h.data_size, 4);
  endfunction

  function automatic void add_bytes(int n);
    for (int i = 0; i < n; i++) file_q.insert(file_q.size(), pick_byte());
  endfunction

  function automatic logic [15:0] valid_bits();
    return 16'(8 * ($urandom_range(3) + 1));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic f);
    while (!no_idle && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    first_i    <= f;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_file(input logic lead_first);
    work_items += file_q.size();
    foreach (file_q[i]) send_byte(file_q[i], lead_first && i == 0);
  endtask

  // well-formed file with n data bytes, trailing bytes after the data are ignored
  task automatic send_valid(input logic [15:0] bits, input logic [31:0] size, input int n,
                            input int trail);
    build_header(rand_hdr(bits, size));
    add_bytes(n);
    add_bytes(trail);
    send_file(1'b1);
  endtask

  // corrupt one checked header byte and cut the file right after it
  task automatic send_broken(input int pos);
    logic [7:0] flip;
    flip = 8'($urandom_range(1, 255));
    build_header(rand_hdr(valid_bits(), pick32()));
    file_q[pos] = file_q[pos] ^ flip;
    while (file_q.size() > pos + 1) void'(file_q.pop_back());
    add_bytes($urandom_range(3));
    send_file(1'b1);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (chk_pending != 0 && guard < 20000);
  endtask

  initial begin
    wpp_pkg::hdr_t h;
    int            roll;
    int            keep;
    logic [15:0]   bits;
    logic [31:0]   size;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    byte_in_i   <= 8'h00;
    first_i     <= 1'b0;
    work_items  = 0;
    file_cnt    = 0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // parser starts in the header without a first flag, wrong riff byte
    file_q = '{8'h00, 8'hA5};
    send_file(1'b0);

    // extreme format fields, 16-bit samples with a short final sample
    h = '{fmt_code: 16'hFFFF, chan_count: 16'h0000, smp_rate: 32'hFFFF_FFFF,
          bytes_per_sec: 32'h0, frame_bytes: 16'hFFFF, sample_bits: 16'd16,
          data_size: 32'd5};
    build_header(h);
    file_q.insert(file_q.size(), 8'h00);
    file_q.insert(file_q.size(), 8'h80);
    file_q.insert(file_q.size(), 8'hFF);
    file_q.insert(file_q.size(), 8'h7F);
    file_q.insert(file_q.size(), 8'h80);
    file_q.insert(file_q.size(), 8'hFF);
    file_q.insert(file_q.size(), 8'h12);
    send_file(1'b1);

    // empty data chunk
    send_valid(16'd32, 32'd0, 0, 1);

    // 24-bit: all ones then a short positive sample
    build_header(rand_hdr(16'd24, 32'd4));
    file_q.insert(file_q.size(), 8'hFF);
    file_q.insert(file_q.size(), 8'hFF);
    file_q.insert(file_q.size(), 8'hFF);
    file_q.insert(file_q.size(), 8'h80);
    send_file(1'b1);

    send_broken(9);
    send_broken(14);
    send_broken(16);
    send_broken(39);

    // unsupported sample size
    build_header(rand_hdr(16'd12, 32'd10));
    add_bytes(2);
    send_file(1'b1);

    // results pile up while the result side holds off
    hold_req = 1'b1;
    send_valid(16'd8, 32'd40, 40, 0);
    drain();

    while (work_items < 1300) begin
      file_cnt++;
      no_idle = (file_cnt >= 8 && file_cnt < 18);
      if (file_cnt == 24) drain();
      roll = $urandom_range(99);
      if (roll < 60) begin
        bits = valid_bits();
        case ($urandom_range(9))
          0:       size = 32'd0;
          1, 2:    size = pick32();
          default: size = $urandom_range(1, 24);
        endcase
        if (size <= 32'd24) send_valid(bits, size, size, $urandom_range(3));
        else                send_valid(bits, size, $urandom_range(1, 16), 0);
      end else if (roll < 70) begin
        case ($urandom_range(4))
          0:       bits = 16'h0000;
          1:       bits = 16'hFFFF;
          default: bits = 16'($urandom_range(65535));
        endcase
        if (bits == 16'd8 || bits == 16'd16 || bits == 16'd24 || bits == 16'd32)
          bits = bits ^ 16'h0001;
        build_header(rand_hdr(bits, pick32()));
        add_bytes($urandom_range(3));
        send_file(1'b1);
      end else if (roll < 88) begin
        case ($urandom_range(4))
          0:       send_broken($urandom_range(3));
          1:       send_broken(8 + $urandom_range(3));
          2:       send_broken(12 + $urandom_range(3));
          3:       send_broken(16 + $urandom_range(3));
          default: send_broken(36 + $urandom_range(3));
        endcase
      end else if (roll < 95) begin
        // header cut short by the next file
        build_header(rand_hdr(valid_bits(), pick32()));
        keep = $urandom_range(1, 43);
        while (file_q.size() > keep) void'(file_q.pop_back());
        send_file(1'b1);
      end else begin
        file_q.delete();
        add_bytes($urandom_range(1, 8));
        send_file(1'b1);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
